### rtl/core/stx_etx_frame_checker_top_defines.svh
// ----------------------------------------------------------------------------
// stx_etx_frame_checker_top_defines
// Assertion macros shared by the frame checker RTL.
// ----------------------------------------------------------------------------
`ifndef STX_ETX_FRAME_CHECKER_TOP_DEFINES_SVH
`define STX_ETX_FRAME_CHECKER_TOP_DEFINES_SVH

// same-cycle implication
`define SEFC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error("sefc assertion failed");

// next-cycle implication
`define SEFC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error("sefc assertion failed");

`endif

### rtl/core/sefc_pkg.sv
// ----------------------------------------------------------------------------
// sefc_pkg
// Types and constants of the STX/ETX frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sefc_pkg;

	localparam int HEADER_LENGTH = 15;
	localparam int HDR_REGS      = 13;
	localparam int POS_W         = 9;
	localparam int TDATA_W       = 120;

	localparam logic [7:0] START_MARK = 8'h50;
	localparam logic [7:0] END_MARK   = 8'h0A;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_START = 3'd1,
		ST_BAD_END   = 3'd2,
		ST_BAD_BCC   = 3'd3,
		ST_WRONG_DST = 3'd4
	} status_t;

	// packed with status in the lowest bits
	typedef struct packed {
		logic [7:0]  payload_length;
		logic [31:0] extra_word;
		logic [7:0]  error_byte;
		logic [7:0]  command_code;
		logic [15:0] destination_id;
		logic [15:0] source_id;
		logic [15:0] frame_number;
		logic [7:0]  flags;
		status_t     status;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/stx_etx_frame_checker_top.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_checker_top
// A verdict item is built from the byte register and leaves through the output register.
// Throughput: one byte per cycle while s_axis_tready is high; the byte register feeds one update stage.
// A two-entry output register holds results while the master side stalls.
// Reset: asynchronous, clears frame state, device_id and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stx_etx_frame_checker_top_defines.svh"

module stx_etx_frame_checker_top
	import sefc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [15:0]        cfg_data,       // device_id
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,   // rx_byte
	input  wire logic               s_axis_tuser,   // frame_start
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// status[2:0], flags, frame_number, source_id, destination_id,
	// command_code, error_byte, extra_word, payload_length, zero pad
	output logic [TDATA_W-1:0]      m_axis_tdata
);

	logic [15:0]      device_id_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;
	logic             in_frame_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       xor_q;
	logic [7:0]       len_q;
	logic [7:0]       header_q [HDR_REGS];
	logic             cks_q;
	result_t          out_q;
	result_t          skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;

	logic [POS_W-1:0] bcc_pos;
	logic             is_verdict;
	logic             has_result;
	logic             push;
	logic             pop;
	logic             accept;
	result_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= '0;
		end else if (cfg_valid) begin
			device_id_q <= cfg_data;
		end
	end

	assign bcc_pos    = POS_W'(len_q) + POS_W'(HEADER_LENGTH);
	assign is_verdict = in_frame_q && (pos_q >= POS_W'(HEADER_LENGTH)) && (pos_q > bcc_pos);
	assign has_result = start_s1 ? (byte_s1 != START_MARK) : is_verdict;
	assign push       = valid_s1 && has_result;
	assign pop        = m_axis_tvalid && m_axis_tready;
	assign accept     = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = !skid_valid_q &&
		!(out_valid_q && !m_axis_tready && valid_s1 && has_result);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			xor_q      <= '0;
			len_q      <= '0;
			cks_q      <= 1'b0;
			for (int i = 0; i < HDR_REGS; i++) begin
				header_q[i] <= '0;
			end
		end else if (valid_s1) begin
			if (start_s1) begin
				xor_q <= '0;
				len_q <= '0;
				cks_q <= 1'b0;
				for (int i = 0; i < HDR_REGS; i++) begin
					header_q[i] <= '0;
				end
				if (byte_s1 != START_MARK) begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
				end else begin
					in_frame_q <= 1'b1;
					pos_q      <= POS_W'(1);
				end
			end else if (in_frame_q) begin
				if (pos_q < POS_W'(HEADER_LENGTH)) begin
					if (pos_q < POS_W'(HEADER_LENGTH - 1)) begin
						for (int i = 0; i < HDR_REGS; i++) begin
							if (pos_q == POS_W'(i + 1)) begin
								header_q[i] <= byte_s1;
							end
						end
					end else begin
						len_q <= byte_s1;
					end
					xor_q <= xor_q ^ byte_s1;
					pos_q <= pos_q + POS_W'(1);
				end else if (pos_q < bcc_pos) begin
					xor_q <= xor_q ^ byte_s1;
					pos_q <= pos_q + POS_W'(1);
				end else if (pos_q == bcc_pos) begin
					cks_q <= (byte_s1 == xor_q);
					pos_q <= pos_q + POS_W'(1);
				end else begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
				end
			end
		end
	end

	// result item
	always_comb begin
		res = '0;
		if (start_s1) begin
			res.status = ST_BAD_START;
		end else begin
			if (byte_s1 != END_MARK) begin
				res.status = ST_BAD_END;
			end else if (!cks_q) begin
				res.status = ST_BAD_BCC;
			end else if ({header_q[6], header_q[5]} != device_id_q) begin
				res.status = ST_WRONG_DST;
			end else begin
				res.status = ST_OK;
			end
			res.flags          = header_q[0];
			res.frame_number   = {header_q[2], header_q[1]};
			res.source_id      = {header_q[4], header_q[3]};
			res.destination_id = {header_q[6], header_q[5]};
			res.command_code   = header_q[7];
			res.error_byte     = header_q[8];
			res.extra_word     = {header_q[12], header_q[11], header_q[10], header_q[9]};
			res.payload_length = len_q;
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_q);

	`SEFC_ASSERT_IMP(a_skid_needs_out, clk, arst_n, skid_valid_q, out_valid_q)
	`SEFC_ASSERT_IMP(a_no_overflow, clk, arst_n, push && out_valid_q && !m_axis_tready, !skid_valid_q)
	`SEFC_ASSERT_IMP(a_idle_pos_zero, clk, arst_n, !in_frame_q, pos_q == '0)
	`SEFC_ASSERT_NXT(a_good_start, clk, arst_n, valid_s1 && start_s1 && (byte_s1 == START_MARK),
		in_frame_q && (pos_q == POS_W'(1)))

endmodule

`default_nettype wire

### bench/stx_etx_frame_checker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_frame_checker_top_tb
// Drives framed bytes with a start flag into the checker and compares every
// verdict item, field by field, with a cycle-free model of the frame parser
// kept in the bench. Covers all status codes, payload size extremes,
// bad and mid-frame starts, stray bytes, several device IDs and random
// traffic with random gaps and back-pressure.
// ----------------------------------------------------------------------------

module stx_etx_frame_checker_top_tb;
	import sefc_pkg::*;

	localparam int RES_W     = $bits(result_t);
	localparam int HUNG_LIMIT = 4000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [15:0]         cfg_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;   // rx_byte
	logic                s_axis_tuser = 1'b0; // frame_start
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b1;
	logic [TDATA_W-1:0]  m_axis_tdata;        // status, flags, ..., payload_length, pad

	stx_etx_frame_checker_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// parser model state
	logic [15:0] own_id = '0;
	int          frame_pos = 0;
	logic        frame_open = 1'b0;
	logic [7:0]  bcc_acc = '0;
	logic [7:0]  pay_len = '0;
	logic [7:0]  hdr_bytes [HDR_REGS];
	logic        bcc_match = 1'b0;

	result_t     verdict_q [$];
	int          fail_cnt = 0;
	int          bytes_in = 0;
	bit          idle_on = 1'b1;
	int          stall_left = 0;
	int          hung_cycles = 0;

	function automatic void track_byte(input logic [7:0] b, input logic st);
		result_t v;
		int bcc_at;
		v = '0;
		if (st) begin
			bcc_acc = '0;
			pay_len = '0;
			bcc_match = 1'b0;
			foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
			if (b != START_MARK) begin
				frame_open = 1'b0;
				frame_pos = 0;
				v.status = ST_BAD_START;
				verdict_q.push_back(v);
			end else begin
				frame_open = 1'b1;
				frame_pos = 1;
			end
		end else if (frame_open) begin
			bcc_at = int'(pay_len) + HEADER_LENGTH;
			if (frame_pos < HEADER_LENGTH) begin
				if (frame_pos < HEADER_LENGTH - 1)
					hdr_bytes[frame_pos - 1] = b;
				else
					pay_len = b;
				bcc_acc ^= b;
				frame_pos++;
			end else if (frame_pos < bcc_at) begin
				bcc_acc ^= b;
				frame_pos++;
			end else if (frame_pos == bcc_at) begin
				bcc_match = (b == bcc_acc);
				frame_pos++;
			end else begin
				if (b != END_MARK)
					v.status = ST_BAD_END;
				else if (!bcc_match)
					v.status = ST_BAD_BCC;
				else if ({hdr_bytes[6], hdr_bytes[5]} != own_id)
					v.status = ST_WRONG_DST;
				else
					v.status = ST_OK;
				v.flags          = hdr_bytes[0];
				v.frame_number   = {hdr_bytes[2], hdr_bytes[1]};
				v.source_id      = {hdr_bytes[4], hdr_bytes[3]};
				v.destination_id = {hdr_bytes[6], hdr_bytes[5]};
				v.command_code   = hdr_bytes[7];
				v.error_byte     = hdr_bytes[8];
				v.extra_word     = {hdr_bytes[12], hdr_bytes[11], hdr_bytes[10], hdr_bytes[9]};
				v.payload_length = pay_len;
				verdict_q.push_back(v);
				frame_open = 1'b0;
				frame_pos = 0;
			end
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		s_axis_tuser = st;
		do @(posedge clk); while (!s_axis_tready);
		track_byte(b, st);
		bytes_in++;
	endtask

	task automatic drain_results(input int settle);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_device_id(input logic [15:0] id);
		drain_results(8);
		cfg_valid = 1'b1;
		cfg_data = id;
		do @(posedge clk); while (!cfg_ready);
		own_id = id;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// keep < 0 sends the whole frame, else only its first keep bytes
	task automatic send_frame(input logic [7:0] flg, input logic [15:0] fnum,
			input logic [15:0] src, input logic [15:0] dst, input logic [7:0] cmd,
			input logic [7:0] err, input logic [31:0] extra, input int plen,
			input bit bad_bcc, input bit bad_end, input int keep);
		logic [7:0] fb [$];
		logic [7:0] x;
		logic [7:0] tail;
		fb = {START_MARK, flg, fnum[7:0], fnum[15:8], src[7:0], src[15:8],
			dst[7:0], dst[15:8], cmd, err, extra[7:0], extra[15:8],
			extra[23:16], extra[31:24], 8'(plen)};
		repeat (plen) fb.push_back(8'($urandom));
		x = '0;
		for (int i = 1; i < fb.size(); i++) x ^= fb[i];
		fb.push_back(bad_bcc ? x ^ (8'h01 << $urandom_range(0, 7)) : x);
		tail = 8'($urandom);
		if (tail == END_MARK) tail ^= 8'h01;
		fb.push_back(bad_end ? tail : END_MARK);
		for (int i = 0; i < fb.size(); i++)
			if (keep < 0 || i < keep) send_byte(fb[i], i == 0);
	endtask

	task automatic random_frame(input int plen, input bit bad_bcc, input bit bad_end,
			input int keep);
		logic [15:0] dst;
		dst = ($urandom_range(0, 3) != 0) ? own_id : 16'($urandom);
		send_frame(8'($urandom), 16'($urandom), 16'($urandom), dst, 8'($urandom),
			8'($urandom), $urandom, plen, bad_bcc, bad_end, keep);
	endtask

	task automatic test_reset_id;
		send_frame(8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 32'h0, 0, 0, 0, -1);
		send_frame(8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1,
			0, 0, -1);
		send_frame(8'hA5, 16'h1234, 16'h5678, 16'h0001, 8'h5A, 8'h3C, 32'hDEAD_BEEF, 2,
			0, 0, -1);
	endtask

	task automatic test_status_codes;
		write_device_id(16'h1234);
		send_frame(8'h01, 16'h0002, 16'h0003, 16'h1234, 8'h04, 8'h05, 32'h0607_0809, 3,
			0, 0, -1);
		send_frame(8'h11, 16'h2222, 16'h3333, 16'h1234, 8'h44, 8'h55, 32'h6666_7777, 4,
			0, 1, -1);
		send_frame(8'h12, 16'h2323, 16'h3434, 16'h1234, 8'h45, 8'h56, 32'h6767_7878, 4,
			1, 0, -1);
		send_frame(8'h13, 16'h2424, 16'h3535, 16'h4321, 8'h46, 8'h57, 32'h6868_7979, 0,
			1, 1, -1);
		send_frame(8'h14, 16'h2525, 16'h3636, 16'h4321, 8'h47, 8'h58, 32'h6969_7A7A, 5,
			0, 0, -1);
		send_frame(8'h15, 16'h2626, 16'h3737, 16'h1235, 8'h48, 8'h59, 32'h6A6A_7B7B, 5,
			1, 0, -1);
	endtask

	task automatic test_start_byte;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h51, 1'b1);
		send_byte(8'h0A, 1'b0);
		random_frame(6, 0, 0, 9);
		send_byte(8'hD0, 1'b1);
		send_byte(8'h50, 1'b0);
		random_frame(6, 0, 0, 20);
		random_frame(2, 0, 0, -1);
	endtask

	task automatic test_stray_bytes;
		send_byte(8'h50, 1'b0);
		send_byte(8'h0A, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		random_frame(0, 0, 0, -1);
	endtask

	task automatic test_payload_sizes;
		random_frame(0, 0, 0, -1);
		random_frame(255, 0, 0, -1);
		random_frame(255, 1, 0, -1);
		random_frame(10, 0, 0, 16);
		random_frame(1, 0, 0, -1);
	endtask

	task automatic test_device_id;
		write_device_id(16'hFFFF);
		send_frame(8'h80, 16'h8000, 16'h0001, 16'hFFFF, 8'h7F, 8'h80, 32'h8000_0001, 0,
			0, 0, -1);
		send_frame(8'h80, 16'h8000, 16'h0001, 16'hFFFE, 8'h7F, 8'h80, 32'h8000_0001, 0,
			0, 0, -1);
		send_frame(8'h80, 16'h8000, 16'h0001, 16'h7FFF, 8'h7F, 8'h80, 32'h8000_0001, 0,
			0, 0, -1);
		write_device_id(16'h0000);
		send_frame(8'h01, 16'h0001, 16'h0001, 16'h0000, 8'h01, 8'h01, 32'h1, 0, 0, 0, -1);
		send_frame(8'h01, 16'h0001, 16'h0001, 16'h0100, 8'h01, 8'h01, 32'h1, 0, 0, 0, -1);
	endtask

	task automatic test_random_traffic(input int budget);
		int mark;
		int r;
		int plen;
		mark = bytes_in;
		while (bytes_in - mark < budget) begin
			r = $urandom_range(0, 15);
			plen = ($urandom_range(0, 40) == 0) ? $urandom_range(21, 255)
				: $urandom_range(0, 20);
			case (r)
				0: random_frame(plen, 1, $urandom_range(0, 3) == 0, -1);
				1: random_frame(plen, 0, 1, -1);
				2: random_frame(plen, 0, 0, $urandom_range(1, plen + 16));
				3: begin
					repeat ($urandom_range(1, 6))
						send_byte(8'($urandom), $urandom_range(0, 7) == 0);
				end
				default: random_frame(plen, 0, 0, -1);
			endcase
			if ($urandom_range(0, 19) == 0) drain_results(0);
		end
	endtask

	// back-pressure on the result side
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready = 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 8);
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		logic [TDATA_W-RES_W-1:0] pad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[RES_W-1:0];
			pad = m_axis_tdata[TDATA_W-1:RES_W];
			if (verdict_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected verdict item: tdata=%h", m_axis_tdata);
			end else begin
				want = verdict_q.pop_front();
				if (got.status !== want.status || got.flags !== want.flags ||
						got.frame_number !== want.frame_number ||
						got.source_id !== want.source_id ||
						got.destination_id !== want.destination_id ||
						got.command_code !== want.command_code ||
						got.error_byte !== want.error_byte ||
						got.extra_word !== want.extra_word ||
						got.payload_length !== want.payload_length || pad !== '0) begin
					fail_cnt++;
					if (fail_cnt <= 10) begin
						$display("verdict mismatch: exp st=%0d fl=%h fn=%h src=%h dst=%h cmd=%h err=%h ext=%h len=%h",
							want.status, want.flags, want.frame_number, want.source_id,
							want.destination_id, want.command_code, want.error_byte,
							want.extra_word, want.payload_length);
						$display("                  got st=%0d fl=%h fn=%h src=%h dst=%h cmd=%h err=%h ext=%h len=%h pad=%h",
							got.status, got.flags, got.frame_number, got.source_id,
							got.destination_id, got.command_code, got.error_byte,
							got.extra_word, got.payload_length, pad);
					end
				end
			end
		end
	end

	// no handshake on any channel for this long means the block is stuck
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			hung_cycles = 0;
		else
			hung_cycles++;
		if (hung_cycles >= HUNG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_reset_id;
		test_status_codes;
		test_start_byte;
		test_stray_bytes;
		test_payload_sizes;
		test_device_id;
		write_device_id(16'($urandom));
		test_random_traffic(300);
		write_device_id(16'hFFFF);
		test_random_traffic(250);
		write_device_id(16'($urandom));
		test_random_traffic(200);
		drain_results(0);
		idle_on = 1'b0;
		test_random_traffic(200);
		drain_results(10);
		if (fail_cnt == 0 && verdict_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### stx_etx_frame_checker_top.f
+incdir+rtl/core
rtl/core/sefc_pkg.sv
rtl/core/stx_etx_frame_checker_top.sv
bench/stx_etx_frame_checker_top_tb.sv
